/* design/spmv_pkg.sv */
// shared constants, codes and types of the sparse matrix-vector multiplier
package spmv_pkg;

  localparam int unsigned VectorDepth = 4096;
  localparam int unsigned AddrW       = $clog2(VectorDepth);
  localparam int unsigned MaxRows     = 65536;
  localparam int unsigned RowW        = $clog2(MaxRows);
  // wide enough for row counter + 1, the row count register and MaxRows itself
  localparam int unsigned CntW        = (RowW + 1 > 17) ? RowW + 1 : 17;

  localparam int unsigned IndexW   = 12;
  localparam int unsigned RowCntW  = 17;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  // register index as decoded from paddr[2]
  localparam logic RegRowCount = 1'b0;

  typedef enum logic [1:0] {
    ReqLoad    = 2'd0,
    ReqNonzero = 2'd1,
    ReqEmpty   = 2'd2
  } req_e;

  // item after the vector read stage
  typedef struct packed {
    logic               close;  // row ends with this item
    logic               nz;     // item carries a product
    logic signed [31:0] value;
    logic signed [31:0] elem;   // vector element at the column
  } stage_t;

endpackage

/* design/spmv_if.sv */
// request and result channel interfaces of the sparse matrix-vector multiplier
interface spmv_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic [spmv_pkg::IndexW-1:0]         index;
  logic signed [31:0]                  value;
  logic                                end_of_row;

  modport source (output valid, req_type, index, value, end_of_row, input ready);
  modport sink   (input valid, req_type, index, value, end_of_row, output ready);
endinterface

interface spmv_res_if;
  logic               valid;
  logic               ready;
  logic [15:0]        row_index;
  logic signed [63:0] row_sum;
  logic               last_row;
  logic               saturated;

  modport source (output valid, row_index, row_sum, last_row, saturated, input ready);
  modport sink   (input valid, row_index, row_sum, last_row, saturated, output ready);
endinterface

/* design/spmv_apb_regs.sv */
// apb register file holding the row count
module spmv_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spmv_pkg::PaddrW-1:0]   paddr,
  input  logic [spmv_pkg::PdataW-1:0]   pwdata,
  output logic [spmv_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output logic [spmv_pkg::RowCntW-1:0]  row_count_o
);

  logic [spmv_pkg::RowCntW-1:0] row_count_q, row_count_d;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    row_count_d = row_count_q;
    if (wr_en && (paddr[2] == spmv_pkg::RegRowCount)) begin
      row_count_d = pwdata[spmv_pkg::RowCntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= spmv_pkg::RowCntW'(1);
    end else begin
      row_count_q <= row_count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == spmv_pkg::RegRowCount) begin
      prdata = spmv_pkg::PdataW'(row_count_q);
    end
  end

  assign row_count_o = row_count_q;

endmodule

/* design/spmv_vec_store.sv */
// vector memory with its write port and the registered column read stage
module spmv_vec_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  spmv_req_if.sink          req_i,
  input  logic              s1_ready_i,
  output logic              s1_valid_o,
  output spmv_pkg::stage_t  s1_o
);

  logic signed [31:0] mem [spmv_pkg::VectorDepth];
  logic signed [31:0] rd_q;

  logic               s1_valid_q;
  logic               close_q, nz_q, in_range_q;
  logic signed [31:0] value_q;

  logic                       take, is_load, is_nz, is_empty, in_range, enter;
  logic [spmv_pkg::AddrW-1:0] addr;

  assign req_i.ready = !s1_valid_q || s1_ready_i;
  assign take        = req_i.valid && req_i.ready;
  assign is_load     = (req_i.req_type == spmv_pkg::ReqLoad);
  assign is_nz       = (req_i.req_type == spmv_pkg::ReqNonzero);
  assign is_empty    = (req_i.req_type == spmv_pkg::ReqEmpty);
  assign in_range    = (32'(req_i.index) < 32'(spmv_pkg::VectorDepth));
  assign addr        = spmv_pkg::AddrW'(req_i.index);
  // loads and unused codes end here, everything else moves on in order
  assign enter       = take && (is_nz || is_empty);

  always_ff @(posedge clk_i) begin
    if (take && is_load && in_range) begin
      mem[addr] <= req_i.value;
    end
    if (take && is_nz) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= enter;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready) begin
      close_q    <= is_empty || (is_nz && req_i.end_of_row);
      nz_q       <= is_nz;
      in_range_q <= in_range;
      value_q    <= req_i.value;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o.close = close_q;
  assign s1_o.nz    = nz_q;
  assign s1_o.value = value_q;
  assign s1_o.elem  = in_range_q ? rd_q : 32'sd0;

endmodule

/* design/spmv_mac.sv */
// product register, saturating row accumulator, row counter and result register
module spmv_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  input  spmv_pkg::stage_t              s1_i,
  output logic                          s1_ready_o,
  input  logic [spmv_pkg::RowCntW-1:0]  row_count_i,
  spmv_res_if.source                    res_o
);

  localparam logic signed [63:0] SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SumMin = 64'sh8000_0000_0000_0000;

  logic                       s2_valid_q, s2_close_q;
  logic signed [63:0]         prod_q, prod_d;
  logic signed [63:0]         acc_q, acc_d, sum;
  logic                       sat_q, sat_d, ovf;
  logic [spmv_pkg::RowW-1:0]  row_cnt_q, row_cnt_d;
  logic [spmv_pkg::CntW-1:0]  cnt_next;
  logic                       last, wrap;
  logic                       out_free, s2_adv, close_now;

  logic                       out_valid_q;
  logic [15:0]                out_row_q;
  logic signed [63:0]         out_sum_q;
  logic                       out_last_q, out_sat_q;

  assign out_free   = !out_valid_q || res_o.ready;
  assign s2_adv     = s2_valid_q && (!s2_close_q || out_free);
  assign s1_ready_o = !s2_valid_q || s2_adv;
  assign close_now  = s2_adv && s2_close_q;

  assign prod_d = s1_i.nz ? (s1_i.value * s1_i.elem) : 64'sd0;

  // saturating add, clamps toward the sign of the accumulator
  always_comb begin
    sum = acc_q + prod_q;
    ovf = (acc_q[63] == prod_q[63]) && (sum[63] != acc_q[63]);
    if (ovf) begin
      sum = acc_q[63] ? SumMin : SumMax;
    end
  end

  assign cnt_next = spmv_pkg::CntW'(row_cnt_q) + spmv_pkg::CntW'(1);
  assign last     = (cnt_next == spmv_pkg::CntW'(row_count_i));
  assign wrap     = (cnt_next >= spmv_pkg::CntW'(spmv_pkg::MaxRows));

  always_comb begin
    acc_d     = acc_q;
    sat_d     = sat_q;
    row_cnt_d = row_cnt_q;
    if (s2_adv) begin
      if (s2_close_q) begin
        acc_d = 64'sd0;
        sat_d = 1'b0;
        if (last || wrap) begin
          row_cnt_d = '0;
        end else begin
          row_cnt_d = cnt_next[spmv_pkg::RowW-1:0];
        end
      end else begin
        acc_d = sum;
        sat_d = sat_q || ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      acc_q       <= 64'sd0;
      sat_q       <= 1'b0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready_o) begin
        s2_valid_q <= s1_valid_i;
      end
      acc_q     <= acc_d;
      sat_q     <= sat_d;
      row_cnt_q <= row_cnt_d;
      if (close_now) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o) begin
      prod_q     <= prod_d;
      s2_close_q <= s1_i.close;
    end
    if (close_now) begin
      out_row_q  <= 16'(row_cnt_q);
      out_sum_q  <= sum;
      out_last_q <= last;
      out_sat_q  <= sat_q || ovf;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.row_index = out_row_q;
  assign res_o.row_sum   = out_sum_q;
  assign res_o.last_row  = out_last_q;
  assign res_o.saturated = out_sat_q;

endmodule

/* design/sparse_csr_matrix_vector_multiply.sv */
// top level of the compressed-row sparse matrix times dense vector multiplier
// usage:
//   req_i carries one transaction per item: load a vector element into the
//   4096-entry store, one matrix nonzero (column, Q16.16 value, end-of-row),
//   or an empty row. res_o carries one transaction per closed row: row number,
//   Q32.32 saturating sum, last-row flag and a saturation flag.
//   the apb port holds row_count at address 0; write it only while idle.
// order: a nonzero or empty row that closes a row has its result valid once it
//   has passed the read register (loaded at acceptance), then the product
//   register, then the result register after the accumulate.
//   loads end at the memory write and give no result.
// throughput: one item per cycle outside a stall, set by the single-port vector
//   read and the one 32x32 multiplier feeding the 64-bit saturating accumulator;
//   a nonzero may read the entry loaded in the cycle right before it.
// reset: row counter, accumulator and saturation flag clear, row_count
//   becomes 1, the pipeline empties; vector store contents stay undefined
//   until loaded, and no clearing pass is needed.
// stall: the result register holds while res_o.ready is low; nonzeros that
//   do not close a row still drain into the accumulator, and req_i.ready
//   falls only once a closing item waits behind the held result.
module sparse_csr_matrix_vector_multiply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  spmv_req_if.sink                      req_i,
  spmv_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spmv_pkg::PaddrW-1:0]   paddr,
  input  logic [spmv_pkg::PdataW-1:0]   pwdata,
  output logic [spmv_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  logic [spmv_pkg::RowCntW-1:0] row_count;
  spmv_pkg::stage_t             s1;
  logic                         s1_valid;
  logic                         s1_ready;

  spmv_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .row_count_o (row_count)
  );

  // stage 1: vector memory write for loads, registered read for nonzeros
  spmv_vec_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .s1_ready_i (s1_ready),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  // stages 2 and 3: multiply, then accumulate and close rows
  spmv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .s1_ready_o  (s1_ready),
    .row_count_i (row_count),
    .res_o       (res_o)
  );

`ifndef ASSERT_OFF
  // input stalls only when the read stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> s1_valid)
    else $error("request stalled with empty read stage");

  // the inner pipeline stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_ready) |-> (res_o.valid && !res_o.ready))
    else $error("pipeline stalled without output back-pressure");

  // a row flagged last restarts numbering at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.last_row) ##1 res_o.valid
      |-> ($past(res_o.ready) ? (res_o.row_index == 16'd0) : 1'b1))
    else $error("row numbering did not restart after last row");
`endif

endmodule
